// ===== rtl/shell_line_tokenizer_core_assert.svh =====
// Assertion macros used by the tokenizer core.
// Needs nothing else; bodies are empty when SYNTHESIS is defined.
`ifndef SHELL_LINE_TOKENIZER_CORE_ASSERT_SVH
`define SHELL_LINE_TOKENIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// holds property prop on every clock edge outside reset
`define SLT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tokenizer assertion failed");
// condition cond never holds outside reset
`define SLT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tokenizer forbidden condition seen");
`else
`define SLT_ASSERT(label, clk, rst_n, prop)
`define SLT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/slt_pkg.sv =====
// Shared types and constants for the shell line tokenizer.
// No dependencies.
package slt_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_WORD_END = 2'd1,
		KIND_STATUS   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PIPE_NONE     = 3'd0,
		PIPE_OK       = 3'd1,
		PIPE_NO_LEFT  = 3'd2,
		PIPE_NO_RIGHT = 3'd3,
		PIPE_SEVERAL  = 3'd4
	} pipe_status_t;

	typedef struct packed {
		kind_t        kind;
		logic [5:0]   token_number;
		logic [7:0]   byte_value;
		logic         starts_token;
		logic         ends_token;
		pipe_status_t status;
		logic [5:0]   token_total;
		logic [5:0]   pipe_position;
		logic         last;
	} result_t;

	// up to two results written per accepted byte, r0 first
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ===== rtl/slt_byte_if.sv =====
// Input channel: one command-line byte per item.
// Uses no package.
interface slt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

// ===== rtl/slt_token_if.sv =====
// Output channel: one token result per item.
// Field codes come from slt_pkg.
interface slt_token_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [5:0] token_number;
	logic [7:0] byte_value;
	logic       starts_token;
	logic       ends_token;
	logic [2:0] status;
	logic [5:0] token_total;
	logic [5:0] pipe_position;
	logic       last;

	modport source (output valid, output kind, output token_number, output byte_value,
		output starts_token, output ends_token, output status, output token_total,
		output pipe_position, output last, input ready);
	modport sink (input valid, input kind, input token_number, input byte_value,
		input starts_token, input ends_token, input status, input token_total,
		input pipe_position, input last, output ready);
endinterface

// ===== rtl/slt_tokenizer.sv =====
// Per-byte tokenizer state and result generation.
// Depends on slt_pkg.
module slt_tokenizer #(
	parameter int TOKEN_LIMIT = 64,
	parameter int WORD_LIMIT  = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      ch,
	output slt_pkg::push_t  push
);
	localparam int TC_W = $clog2(TOKEN_LIMIT);
	localparam int WL_W = $clog2(WORD_LIMIT + 1);

	logic            in_word_q, stopped_q, pipe_seen_q, after_pipe_q, second_pipe_q;
	logic            in_word_d, stopped_d, pipe_seen_d, after_pipe_d, second_pipe_d;
	logic [TC_W-1:0] token_count_q, token_count_d, first_pipe_q, first_pipe_d;
	logic [WL_W-1:0] word_len_q, word_len_d;

	logic [TC_W+5:0] cur_ext, prev_ext, first_ext;
	logic            at_limit, is_op, closing, has_main;
	logic [1:0]      n_res;
	slt_pkg::result_t eow, main_r, r0, r1;
	slt_pkg::pipe_status_t pstat;

	// wide counters wrap into the 6-bit fields
	assign cur_ext   = {6'd0, token_count_q};
	assign prev_ext  = {6'd0, token_count_q - TC_W'(1)};
	assign first_ext = {6'd0, first_pipe_q};
	assign at_limit  = token_count_q >= TC_W'(TOKEN_LIMIT - 1);
	assign is_op     = (ch == slt_pkg::CH_GT) || (ch == slt_pkg::CH_LT) ||
		(ch == slt_pkg::CH_PIPE);

	always_comb begin
		if (!pipe_seen_q)
			pstat = slt_pkg::PIPE_NONE;
		else if (first_pipe_q == '0)
			pstat = slt_pkg::PIPE_NO_LEFT;
		else if (!after_pipe_q)
			pstat = slt_pkg::PIPE_NO_RIGHT;
		else if (second_pipe_q)
			pstat = slt_pkg::PIPE_SEVERAL;
		else
			pstat = slt_pkg::PIPE_OK;
	end

	always_comb begin
		in_word_d     = in_word_q;
		stopped_d     = stopped_q;
		pipe_seen_d   = pipe_seen_q;
		after_pipe_d  = after_pipe_q;
		second_pipe_d = second_pipe_q;
		token_count_d = token_count_q;
		first_pipe_d  = first_pipe_q;
		word_len_d    = word_len_q;
		closing       = 1'b0;
		has_main      = 1'b0;
		eow           = '0;
		main_r        = '0;
		eow.kind         = slt_pkg::KIND_WORD_END;
		eow.token_number = prev_ext[5:0];

		if (ch == slt_pkg::CH_NUL) begin
			// line end: close word, report, back to reset state
			closing              = in_word_q;
			has_main             = 1'b1;
			main_r.kind          = slt_pkg::KIND_STATUS;
			main_r.status        = pstat;
			main_r.token_total   = cur_ext[5:0];
			main_r.pipe_position = pipe_seen_q ? first_ext[5:0] : 6'd0;
			main_r.last          = 1'b1;
			in_word_d     = 1'b0;
			stopped_d     = 1'b0;
			pipe_seen_d   = 1'b0;
			after_pipe_d  = 1'b0;
			second_pipe_d = 1'b0;
			token_count_d = '0;
			first_pipe_d  = '0;
			word_len_d    = '0;
		end else if (!stopped_q) begin
			if (ch == slt_pkg::CH_SPACE) begin
				closing    = in_word_q;
				in_word_d  = 1'b0;
				word_len_d = '0;
			end else if (is_op) begin
				closing    = in_word_q;
				in_word_d  = 1'b0;
				word_len_d = '0;
				if (at_limit) begin
					stopped_d = 1'b1;
				end else begin
					after_pipe_d = after_pipe_q | pipe_seen_q;
					if (ch == slt_pkg::CH_PIPE) begin
						if (!pipe_seen_q) begin
							pipe_seen_d  = 1'b1;
							first_pipe_d = token_count_q;
						end else begin
							second_pipe_d = 1'b1;
						end
					end
					has_main            = 1'b1;
					main_r.kind         = slt_pkg::KIND_BYTE;
					main_r.token_number = cur_ext[5:0];
					main_r.byte_value   = ch;
					main_r.starts_token = 1'b1;
					main_r.ends_token   = 1'b1;
					token_count_d       = token_count_q + TC_W'(1);
				end
			end else if (in_word_q) begin
				// bytes past the word limit are dropped
				if (word_len_q < WL_W'(WORD_LIMIT)) begin
					word_len_d          = word_len_q + WL_W'(1);
					has_main            = 1'b1;
					main_r.kind         = slt_pkg::KIND_BYTE;
					main_r.token_number = prev_ext[5:0];
					main_r.byte_value   = ch;
				end
			end else if (at_limit) begin
				stopped_d = 1'b1;
			end else begin
				after_pipe_d        = after_pipe_q | pipe_seen_q;
				in_word_d           = 1'b1;
				word_len_d          = WL_W'(1);
				has_main            = 1'b1;
				main_r.kind         = slt_pkg::KIND_BYTE;
				main_r.token_number = cur_ext[5:0];
				main_r.byte_value   = ch;
				main_r.starts_token = 1'b1;
				token_count_d       = token_count_q + TC_W'(1);
			end
		end

		// word-end result goes ahead of whatever this byte produces
		if (closing) begin
			r0    = eow;
			r1    = main_r;
			n_res = has_main ? 2'd2 : 2'd1;
		end else begin
			r0    = main_r;
			r1    = '0;
			n_res = {1'b0, has_main};
		end
	end

	assign push.count = accept ? n_res : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q     <= 1'b0;
			stopped_q     <= 1'b0;
			pipe_seen_q   <= 1'b0;
			after_pipe_q  <= 1'b0;
			second_pipe_q <= 1'b0;
			token_count_q <= '0;
			first_pipe_q  <= '0;
			word_len_q    <= '0;
		end else if (accept) begin
			in_word_q     <= in_word_d;
			stopped_q     <= stopped_d;
			pipe_seen_q   <= pipe_seen_d;
			after_pipe_q  <= after_pipe_d;
			second_pipe_q <= second_pipe_d;
			token_count_q <= token_count_d;
			first_pipe_q  <= first_pipe_d;
			word_len_q    <= word_len_d;
		end
	end

endmodule

// ===== rtl/slt_queue.sv =====
// Four-entry result queue: up to two writes, one read per cycle.
// Depends on slt_pkg.
module slt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  slt_pkg::push_t   push,
	input  logic             pop,
	output logic             space,
	output logic             head_valid,
	output slt_pkg::result_t head
);
	slt_pkg::result_t entry_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;

	// room for a full two-result push
	assign space      = count_q <= 3'd2;
	assign head_valid = count_q != 3'd0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entry_q[wr_ptr_q] <= push.r0;
		if (push.count == 2'd2)
			entry_q[wr_ptr_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

endmodule

// ===== rtl/shell_line_tokenizer_core.sv =====
// Shell line tokenizer: one command-line byte in, token results out.
// A byte's results are registered in the queue on accept and leave it in arrival order.
// Throughput: one byte per cycle while the four-entry queue has room for two results.
//   The output drains one result per cycle while ready, so bytes that close a word and
//   add an operator or the line status can fill it; input is held off until two free.
// Reset (arst_n low, asynchronous) clears tokenizer state and empties the queue.
`include "shell_line_tokenizer_core_assert.svh"
module shell_line_tokenizer_core #(
	parameter int TOKEN_LIMIT = 64,   // tokens kept per line is TOKEN_LIMIT-1
	parameter int WORD_LIMIT  = 1024  // bytes kept per word token
) (
	input logic        clk,
	input logic        arst_n,
	slt_byte_if.sink   line,
	slt_token_if.source token
);
	slt_pkg::push_t   push;
	slt_pkg::result_t head;
	logic             space, head_valid, accept, pop;

	// Bytes are taken whenever the queue can hold a worst-case two-result push,
	// so the output side stalling never loses a result.
	assign line.ready = space;
	assign accept     = line.valid & line.ready;
	assign pop        = token.valid & token.ready;

	// Results for one byte are formed combinationally; its state updates when it is accepted.
	slt_tokenizer #(
		.TOKEN_LIMIT (TOKEN_LIMIT),
		.WORD_LIMIT  (WORD_LIMIT)
	) u_tokenizer (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.ch     (line.ch),
		.push   (push)
	);

	// Result registers: separate the producer from output backpressure.
	slt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.space      (space),
		.head_valid (head_valid),
		.head       (head)
	);

	assign token.valid         = head_valid;
	assign token.kind          = head.kind;
	assign token.token_number  = head.token_number;
	assign token.byte_value    = head.byte_value;
	assign token.starts_token  = head.starts_token;
	assign token.ends_token    = head.ends_token;
	assign token.status        = head.status;
	assign token.token_total   = head.token_total;
	assign token.pipe_position = head.pipe_position;
	assign token.last          = head.last;

	// a byte never yields more than two results
	`SLT_ASSERT_NEVER(a_push_max, clk, arst_n, push.count == 2'd3)
	// nothing is written while input is held off
	`SLT_ASSERT(a_no_push_stalled, clk, arst_n, !accept |-> push.count == 2'd0)
	// line end always produces the status result as its final write
	`SLT_ASSERT(a_line_end_status, clk, arst_n,
		(accept && line.ch == slt_pkg::CH_NUL) |->
		((push.count == 2'd1 && push.r0.last) || (push.count == 2'd2 && push.r1.last)))
	// a result marked last is always a status result
	`SLT_ASSERT(a_last_is_status, clk, arst_n,
		(token.valid && token.last) |-> token.kind == slt_pkg::KIND_STATUS)

endmodule
